// ===== hdl/vfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Volume flow statistics package
// Field widths, controller states, command and status groups, and the
// saturating accumulate shared by the statistics block.
// ----------------------------------------------------------------------------
package vfs_pkg;

   localparam int VelW      = 16;
   localparam int DensW     = 16;
   localparam int XSizeW    = 13;
   localparam int CountW    = 24;
   localparam int SumW      = 48;
   localparam int SqW       = 32;
   localparam int RootW     = SqW / 2;
   localparam int RootSteps = RootW;
   localparam int StepW     = $clog2(RootSteps);
   localparam int RemW      = RootW + 3;

   localparam logic [XSizeW-1:0] XSizeReset = XSizeW'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_MUL,
      ST_ACC
   } vfs_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic square;
      logic sum;
      logic root_step;
      logic mul;
      logic acc;
   } vfs_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic voxel_valid;
      logic voxel_last;
      logic out_busy;
   } vfs_status_type;

   // Adds a 32-bit product into a 48-bit sum, clamping at all ones.
   function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] acc,
                                               input logic [SqW-1:0]  add);
      logic [SumW:0] total;
      total = {1'b0, acc} + (SumW + 1)'(add);
      return total[SumW] ? {SumW{1'b1}} : total[SumW-1:0];
   endfunction

endpackage

// ===== hdl/vfs_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel request channel
// Valid/ready channel that carries one voxel per beat.
// ----------------------------------------------------------------------------
interface vfs_req_if;

   logic                                    valid;
   logic                                    ready;
   logic                                    valid_req;
   logic signed [vfs_pkg::VelW-1:0]         vel_x;
   logic signed [vfs_pkg::VelW-1:0]         vel_y;
   logic signed [vfs_pkg::VelW-1:0]         vel_z;
   logic        [vfs_pkg::DensW-1:0]        density;
   logic                                    last;

   modport source (output valid, valid_req, vel_x, vel_y, vel_z, density, last,
                   input ready);
   modport sink   (input valid, valid_req, vel_x, vel_y, vel_z, density, last,
                   output ready);

endinterface

// ===== hdl/vfs_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Statistics response channel
// Valid/ready channel that carries the volume totals, one beat per volume.
// ----------------------------------------------------------------------------
interface vfs_rsp_if;

   logic                             valid;
   logic                             ready;
   logic [vfs_pkg::CountW-1:0]       neg_count;
   logic [vfs_pkg::SumW-1:0]         inflow_sum;
   logic [vfs_pkg::SumW-1:0]         outflow_sum;

   modport source (output valid, neg_count, inflow_sum, outflow_sum, input ready);
   modport sink   (input valid, neg_count, inflow_sum, outflow_sum, output ready);

endinterface

// ===== hdl/vfs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Volume flow statistics controller
// Sequences a voxel: squaring, then sum, square root and multiply if valid, then accumulation.
// ----------------------------------------------------------------------------
module vfs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_accept,
   output logic                    req_ready,
   input  vfs_pkg::vfs_status_type status,
   output vfs_pkg::vfs_cmd_type    cmd
);
   import vfs_pkg::*;

   localparam logic [StepW-1:0] LastStep = StepW'(RootSteps - 1);

   vfs_state_type    state_ff, state_in;
   logic [StepW-1:0] step_ff, step_in;
   logic             out_blocked;

   // The final voxel waits while an earlier result still sits unread.
   assign out_blocked = status.voxel_last && status.out_busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            state_in = status.voxel_valid ? ST_SUM : ST_ACC;
         end
         ST_SUM: begin
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (step_ff == LastStep) state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (!out_blocked) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      step_in = '0;
      if (state_ff == ST_ROOT && step_ff != LastStep) step_in = step_ff + StepW'(1);
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_accept;
         end
         ST_SQUARE: cmd.square    = 1'b1;
         ST_SUM:    cmd.sum       = 1'b1;
         ST_ROOT:   cmd.root_step = 1'b1;
         ST_MUL:    cmd.mul       = 1'b1;
         ST_ACC:    cmd.acc       = !out_blocked;
         default:   cmd           = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // The root step counter runs only inside the root iterations.
   a_step_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ROOT) |-> (step_ff == '0))
      else $error("root step counter active outside the root iterations");

   // A voxel accepted in idle always starts with the squaring step.
   a_accept_square: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_SQUARE))
      else $error("accepted voxel did not proceed to squaring");

   // Accumulation never happens while the final voxel would overwrite a result.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.acc |-> !out_blocked)
      else $error("accumulate issued while the result register is held");

endmodule

// ===== hdl/vfs_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Volume flow statistics datapath
// Magnitude by squares and a bit-pair square root, then the count, the two
// saturating sums, the column tracker and the result register.
// ----------------------------------------------------------------------------
module vfs_datapath #(
   parameter int MAX_COLUMNS = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  vfs_pkg::vfs_cmd_type              cmd,
   output vfs_pkg::vfs_status_type           status,
   input  logic                              csr_we,
   input  logic [vfs_pkg::XSizeW-1:0]        csr_wdata,
   input  logic                              in_valid_req,
   input  logic signed [vfs_pkg::VelW-1:0]   in_vel_x,
   input  logic signed [vfs_pkg::VelW-1:0]   in_vel_y,
   input  logic signed [vfs_pkg::VelW-1:0]   in_vel_z,
   input  logic [vfs_pkg::DensW-1:0]         in_density,
   input  logic                              in_last,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [vfs_pkg::CountW-1:0]        out_neg_count,
   output logic [vfs_pkg::SumW-1:0]          out_inflow_sum,
   output logic [vfs_pkg::SumW-1:0]          out_outflow_sum
);
   import vfs_pkg::*;

   localparam int ColW = $clog2(MAX_COLUMNS);
   localparam int XExtW = $clog2(MAX_COLUMNS) + XSizeW + 1;

   logic [XSizeW-1:0] xsize_ff;
   logic [VelW-1:0]   abs_x_ff, abs_y_ff, abs_z_ff;
   logic [DensW-1:0]  dens_ff;
   logic              vox_valid_ff, vox_last_ff, vox_neg_ff;
   logic [SqW-1:0]    sq_x_ff, sq_y_ff, sq_z_ff;
   logic [SqW-1:0]    rad_ff;
   logic [RemW-1:0]   rem_ff;
   logic [RootW-1:0]  root_ff;
   logic [SqW-1:0]    prod_ff;
   logic [ColW-1:0]   column_ff, column_in;
   logic [CountW-1:0] neg_total_ff, neg_total_in;
   logic [SumW-1:0]   inflow_ff, inflow_in;
   logic [SumW-1:0]   outflow_ff, outflow_in;
   logic              rsp_valid_ff;
   logic [CountW-1:0] rsp_count_ff;
   logic [SumW-1:0]   rsp_inflow_ff, rsp_outflow_ff;

   logic [XExtW-1:0]  xs_ext;
   logic [ColW-1:0]   xs_m1;
   logic              first_col, last_col;
   logic [RemW-1:0]   rem_shift, trial;
   logic              fits;

   function automatic logic [VelW-1:0] mag16(input logic signed [VelW-1:0] v);
      return v[VelW-1] ? VelW'(~v + VelW'(1)) : VelW'(v);
   endfunction

   // Effective row length minus one, clamped to the legal range.
   assign xs_ext = XExtW'(xsize_ff);
   always_comb begin
      priority if (xsize_ff == '0) begin
         xs_m1 = '0;
      end else if (xs_ext > XExtW'(MAX_COLUMNS)) begin
         xs_m1 = ColW'(MAX_COLUMNS - 1);
      end else begin
         xs_m1 = ColW'(xs_ext - XExtW'(1));
      end
   end

   assign first_col = (column_ff == '0);
   assign last_col  = (column_ff == xs_m1);

   // One result bit per step, two radicand bits shifted into the remainder.
   assign rem_shift = {rem_ff[RemW-3:0], rad_ff[SqW-1 -: 2]};
   assign trial     = RemW'({root_ff, 2'b01});
   assign fits      = (rem_shift >= trial);

   always_comb begin
      neg_total_in = neg_total_ff;
      inflow_in    = inflow_ff;
      outflow_in   = outflow_ff;
      if (vox_valid_ff) begin
         if (vox_neg_ff && neg_total_ff != {CountW{1'b1}})
            neg_total_in = neg_total_ff + CountW'(1);
         if (first_col) inflow_in = sat_add(inflow_ff, prod_ff);
         if (last_col)  outflow_in = sat_add(outflow_ff, prod_ff);
      end
      column_in = (column_ff >= xs_m1) ? '0 : column_ff + ColW'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         abs_x_ff     <= mag16(in_vel_x);
         abs_y_ff     <= mag16(in_vel_y);
         abs_z_ff     <= mag16(in_vel_z);
         dens_ff      <= in_density;
         vox_valid_ff <= in_valid_req;
         vox_last_ff  <= in_last;
         vox_neg_ff   <= in_vel_x[VelW-1];
      end
      if (cmd.square) begin
         sq_x_ff <= SqW'(abs_x_ff) * SqW'(abs_x_ff);
         sq_y_ff <= SqW'(abs_y_ff) * SqW'(abs_y_ff);
         sq_z_ff <= SqW'(abs_z_ff) * SqW'(abs_z_ff);
      end
      if (cmd.sum) begin
         rad_ff  <= sq_x_ff + sq_y_ff + sq_z_ff;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.root_step) begin
         rad_ff  <= {rad_ff[SqW-3:0], 2'b00};
         rem_ff  <= fits ? rem_shift - trial : rem_shift;
         root_ff <= {root_ff[RootW-2:0], fits};
      end
      if (cmd.mul) prod_ff <= SqW'(dens_ff) * SqW'(root_ff);
      if (cmd.acc && vox_last_ff) begin
         rsp_count_ff   <= neg_total_in;
         rsp_inflow_ff  <= inflow_in;
         rsp_outflow_ff <= outflow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xsize_ff     <= XSizeReset;
         column_ff    <= '0;
         neg_total_ff <= '0;
         inflow_ff    <= '0;
         outflow_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) xsize_ff <= csr_wdata;
         if (cmd.acc) begin
            if (vox_last_ff) begin
               column_ff    <= '0;
               neg_total_ff <= '0;
               inflow_ff    <= '0;
               outflow_ff   <= '0;
            end else begin
               column_ff    <= column_in;
               neg_total_ff <= neg_total_in;
               inflow_ff    <= inflow_in;
               outflow_ff   <= outflow_in;
            end
         end
         if (cmd.acc && vox_last_ff) rsp_valid_ff <= 1'b1;
         else if (out_ready)         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.voxel_valid = vox_valid_ff;
   assign status.voxel_last  = vox_last_ff;
   assign status.out_busy    = rsp_valid_ff && !out_ready;

   assign out_valid       = rsp_valid_ff;
   assign out_neg_count   = rsp_count_ff;
   assign out_inflow_sum  = rsp_inflow_ff;
   assign out_outflow_sum = rsp_outflow_ff;

   // A result appears only right after the final voxel was accumulated.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.acc && vox_last_ff))
      else $error("result raised without a final voxel");

   // The totals restart from zero after each volume.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.acc && vox_last_ff) |=>
         (neg_total_ff == '0 && inflow_ff == '0 && outflow_ff == '0 && column_ff == '0))
      else $error("state not cleared after the final voxel");

   // The root keeps the remainder within twice the partial root.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.root_step |=> (rem_ff <= RemW'({root_ff, 1'b0})))
      else $error("square root remainder out of bound");

endmodule

// ===== hdl/volume_flow_statistics.sv =====
// A valid voxel is squared, summed, passed through the root iterations and
// multiplied, then accumulated; the totals beat is offered the cycle after the
// final voxel is accumulated. A new voxel is taken only once the last one is
// done, valid voxels being held by the 16 iterations of the bit-pair square root.
// Reset (synchronous, active high) clears the totals, the column and the result valid.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Volume flow statistics
// Counts valid voxels with negative x velocity and sums density times velocity
// magnitude in the first and last columns of a voxel stream, reporting per volume.
// ----------------------------------------------------------------------------
//
// Voxels arrive in raster order, x fastest. The controller takes one voxel at
// a time: squares of the three velocity components are formed in parallel,
// summed, and passed to a one-bit-per-cycle square root. The magnitude times
// the density then goes into the inflow sum for column 0 and into the outflow
// sum for the last column; when the row is one voxel wide both sums see it.
// The column tracker advances on every voxel, valid or not.
//
// On the voxel flagged last, the totals including that voxel are loaded into
// the result register and all state returns to zero. The result register
// parts the two channels; a later volume's final voxel waits in the
// accumulate step only while an earlier result beat is still unread.
//
// The row length register is to be written (csr_we/csr_wdata) only while idle;
// the block does not enforce it. Zero acts as one, above MAX_COLUMNS as MAX_COLUMNS.
module volume_flow_statistics #(
   parameter int MAX_COLUMNS = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   vfs_req_if.sink                      req_bus,
   vfs_rsp_if.source                    rsp_bus,
   input  logic                         csr_we,
   input  logic [vfs_pkg::XSizeW-1:0]   csr_wdata
);
   import vfs_pkg::*;

   vfs_cmd_type    cmd;
   vfs_status_type status;
   logic           req_ready;
   logic           req_accept;

   // A beat is taken whenever the controller sits idle.
   assign req_bus.ready = req_ready;
   assign req_accept    = req_bus.valid && req_ready;

   vfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   vfs_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .in_valid_req    (req_bus.valid_req),
      .in_vel_x        (req_bus.vel_x),
      .in_vel_y        (req_bus.vel_y),
      .in_vel_z        (req_bus.vel_z),
      .in_density      (req_bus.density),
      .in_last         (req_bus.last),
      .out_valid       (rsp_bus.valid),
      .out_ready       (rsp_bus.ready),
      .out_neg_count   (rsp_bus.neg_count),
      .out_inflow_sum  (rsp_bus.inflow_sum),
      .out_outflow_sum (rsp_bus.outflow_sum)
   );

endmodule

// ===== sim/volume_flow_statistics_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Volume flow statistics testbench
// Streams voxel beats into the statistics block under several row lengths and
// handshake pressures, predicts the per-volume totals in a scoreboard and
// compares every totals beat against the oldest prediction.
// ----------------------------------------------------------------------------
module volume_flow_statistics_tb;

   import vfs_pkg::*;

   localparam int MaxColumns   = 4096;
   localparam int ResetCycles  = 12;
   // Time allowed for a voxel that is still in flight without producing a beat.
   localparam int SettleCycles = 30;
   // Cycles without any accepted beat before the run is declared hung.
   localparam int StallLimit   = 4000;
   localparam int NumPhases    = 9;
   localparam int ItemsPerPhase = 190;
   // Rows at least this wide are covered by one long, mostly invalid, volume.
   localparam int LongRow      = 1024;
   localparam int ReportLimit  = 10;

   typedef struct {
      logic                    valid_req;
      logic signed [VelW-1:0]  vel_x;
      logic signed [VelW-1:0]  vel_y;
      logic signed [VelW-1:0]  vel_z;
      logic [DensW-1:0]        density;
      logic                    last;
   } voxel_type;

   typedef struct {
      logic [CountW-1:0] neg_count;
      logic [SumW-1:0]   inflow_sum;
      logic [SumW-1:0]   outflow_sum;
   } totals_type;

   // Scoreboard: keeps its own copy of the row length, the column tracker and
   // the three running totals, and queues the totals of every finished volume.
   class flow_totals_board_type;
      logic [XSizeW-1:0] row_len;
      int unsigned       column;
      logic [CountW-1:0] neg_total;
      logic [SumW-1:0]   inflow_acc;
      logic [SumW-1:0]   outflow_acc;
      totals_type        expected_totals[$];
      int unsigned       mismatches;

      function new();
         row_len     = XSizeReset;
         column      = 0;
         neg_total   = '0;
         inflow_acc  = '0;
         outflow_acc = '0;
         mismatches  = 0;
      endfunction

      function void set_row_len(logic [XSizeW-1:0] value);
         row_len = value;
      endfunction

      function int unsigned pending();
         return expected_totals.size();
      endfunction

      static function longint unsigned component_square(logic signed [VelW-1:0] c);
         longint s;
         s = c;
         return s * s;
      endfunction

      // Floor square root, one result bit per trial from the top down.
      static function logic [RootW-1:0] floor_root(longint unsigned sq);
         logic [RootW-1:0] root;
         logic [RootW-1:0] trial;
         longint unsigned  wide;
         root = '0;
         for (int b = RootW - 1; b >= 0; b--) begin
            trial = root | (RootW'(1) << b);
            wide  = trial;
            if (wide * wide <= sq) root = trial;
         end
         return root;
      endfunction

      static function logic [SumW-1:0] clamp_add(logic [SumW-1:0] acc,
                                                 longint unsigned add);
         longint unsigned s;
         s = acc;
         s = s + add;
         return (s > {SumW{1'b1}}) ? {SumW{1'b1}} : s[SumW-1:0];
      endfunction

      // Applies one accepted voxel and queues totals when it closes a volume.
      function void accumulate_voxel(voxel_type v);
         int unsigned     span;
         bit              first_col;
         bit              last_col;
         longint unsigned sq;
         longint unsigned prod;
         totals_type      done;
         span = (row_len == 0) ? 1 : ((row_len > MaxColumns) ? MaxColumns : row_len);
         first_col = (column == 0);
         last_col  = (column == span - 1);
         if (v.valid_req) begin
            sq   = component_square(v.vel_x) + component_square(v.vel_y)
                 + component_square(v.vel_z);
            prod = v.density;
            prod = prod * floor_root(sq);
            if (v.vel_x[VelW-1] && neg_total != {CountW{1'b1}}) neg_total++;
            if (first_col) inflow_acc = clamp_add(inflow_acc, prod);
            if (last_col) outflow_acc = clamp_add(outflow_acc, prod);
         end
         column = (column >= span - 1) ? 0 : column + 1;
         if (v.last) begin
            done = '{neg_total, inflow_acc, outflow_acc};
            expected_totals = {expected_totals, done};
            column      = 0;
            neg_total   = '0;
            inflow_acc  = '0;
            outflow_acc = '0;
         end
      endfunction

      function void check_totals(totals_type got);
         totals_type want;
         if (expected_totals.size() == 0) begin
            mismatches++;
            if (mismatches <= ReportLimit)
               $display("%0t: totals beat with none pending: neg %0d in %h out %h",
                        $realtime, got.neg_count, got.inflow_sum, got.outflow_sum);
            return;
         end
         want = expected_totals.pop_front();
         if (got.neg_count !== want.neg_count || got.inflow_sum !== want.inflow_sum ||
             got.outflow_sum !== want.outflow_sum) begin
            mismatches++;
            if (mismatches <= ReportLimit)
               $display("%0t: totals mismatch: neg exp %0d got %0d, in exp %h got %h, %s %h got %h",
                        $realtime, want.neg_count, got.neg_count, want.inflow_sum,
                        got.inflow_sum, "out exp", want.outflow_sum, got.outflow_sum);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [XSizeW-1:0] csr_wdata;

   vfs_req_if req_bus ();
   vfs_rsp_if rsp_bus ();

   flow_totals_board_type board = new();

   // Percentage of cycles in which the sender holds back a beat and in which
   // the receiver drops ready. The main sequence changes them between phases.
   int send_gap_pct = 7;
   int recv_gap_pct = 68;

   // Row length used by each random phase. Zero is among them, and one row is
   // wide enough that its volumes of whole rows each span a single row.
   int phase_row_len [NumPhases];

   volume_flow_statistics #(
      .MAX_COLUMNS(MaxColumns)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Both channels are sampled at the rising edge, where everything driven at
   // the falling edge is stable. Totals are checked before the voxel of the
   // same edge is noted, although a voxel can never close its volume that fast.
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (rsp_bus.valid && rsp_bus.ready)
            board.check_totals('{rsp_bus.neg_count, rsp_bus.inflow_sum,
                                 rsp_bus.outflow_sum});
         if (req_bus.valid && req_bus.ready)
            board.accumulate_voxel('{req_bus.valid_req, req_bus.vel_x, req_bus.vel_y,
                                     req_bus.vel_z, req_bus.density, req_bus.last});
      end
   end

   // The receiver drops ready at random, at the rate of the current phase.
   initial begin : totals_ready_driver
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
   end

   // Watchdog: the run is hung when no beat of any kind moves for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < StallLimit) begin
         @(posedge clock);
         if (reset !== 1'b0 || csr_we || (req_bus.valid && req_bus.ready) ||
             (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   function automatic logic signed [VelW-1:0] pick_velocity();
      case ($urandom_range(0, 19))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'shFFFF;
         3: return 16'sh0001;
         4: return '0;
         default: return VelW'($urandom);
      endcase
   endfunction

   function automatic logic [DensW-1:0] pick_density();
      case ($urandom_range(0, 19))
         0: return '0;
         1: return '1;
         default: return DensW'($urandom);
      endcase
   endfunction

   function automatic voxel_type make_voxel(logic valid_req, logic [VelW-1:0] vx,
                                            logic [VelW-1:0] vy, logic [VelW-1:0] vz,
                                            logic [DensW-1:0] dens, logic last);
      voxel_type v;
      v.valid_req = valid_req;
      v.vel_x     = vx;
      v.vel_y     = vy;
      v.vel_z     = vz;
      v.density   = dens;
      v.last      = last;
      return v;
   endfunction

   function automatic voxel_type random_voxel(logic valid_req, logic last);
      return make_voxel(valid_req, pick_velocity(), pick_velocity(), pick_velocity(),
                        pick_density(), last);
   endfunction

   // Offers one voxel beat. Every assignment falls on its own falling edge, so
   // valid is never lowered and raised within one time step. The task returns
   // at the rising edge where the beat is accepted, with valid still high.
   task automatic send_voxel(voxel_type v);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.valid_req <= v.valid_req;
      req_bus.vel_x     <= v.vel_x;
      req_bus.vel_y     <= v.vel_y;
      req_bus.vel_z     <= v.vel_z;
      req_bus.density   <= v.density;
      req_bus.last      <= v.last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Holds the sender off until every predicted totals beat has been taken.
   task automatic wait_for_totals();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
   endtask

   // The row length may only change while the block is idle: all totals are
   // out and any voxel still in the datapath has had time to retire.
   task automatic write_row_len(logic [XSizeW-1:0] value);
      wait_for_totals();
      repeat (SettleCycles) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      board.set_row_len(value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      int  span;
      int  len;
      int  sent;
      int  vol;
      int  gen_col;
      bit  keep;

      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.valid_req = 1'b0;
      req_bus.vel_x     = '0;
      req_bus.vel_y     = '0;
      req_bus.vel_z     = '0;
      req_bus.density   = '0;
      req_bus.last      = 1'b0;
      phase_row_len     = '{2, 3, 1, 5, 0, 9, 40, 12, 4};

      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. The first volume runs on the reset row length of one,
      // so each voxel is both first and last column. It covers the largest
      // magnitude in both signs, full density, and an invalid voxel that must
      // add nothing even though its x velocity is negative.
      send_voxel(make_voxel(1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b0));
      send_voxel(make_voxel(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 1'b0));
      send_voxel(make_voxel(1'b0, 16'h8000, 16'h1234, 16'hABCD, 16'hFFFF, 1'b0));
      send_voxel(make_voxel(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));

      // A row length of zero behaves as one.
      write_row_len('0);
      send_voxel(make_voxel(1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0100, 1'b0));
      send_voxel(make_voxel(1'b1, 16'h0001, 16'h0000, 16'h0000, 16'h0100, 1'b1));

      // Three columns: first, middle and last column, then an invalid voxel
      // that still moves the column on.
      write_row_len(XSizeW'(3));
      send_voxel(make_voxel(1'b1, 16'h0300, 16'h0400, 16'h0000, 16'h0200, 1'b0));
      send_voxel(make_voxel(1'b1, 16'hFF00, 16'h0100, 16'h0000, 16'h0100, 1'b0));
      send_voxel(make_voxel(1'b1, 16'h0100, 16'hFE00, 16'h0080, 16'h0300, 1'b0));
      send_voxel(make_voxel(1'b0, 16'h0500, 16'h0000, 16'h0000, 16'h0100, 1'b0));
      send_voxel(make_voxel(1'b1, 16'h0000, 16'h0000, 16'h0A00, 16'h0100, 1'b1));

      // Row shrinks mid-row: three voxels leave the column at 3, then a width
      // of two puts it past the last column, so the next voxel counts as
      // neither first nor last and the column wraps to zero.
      write_row_len(XSizeW'(4));
      send_voxel(make_voxel(1'b1, 16'h0100, 16'h0000, 16'h0000, 16'h0100, 1'b0));
      send_voxel(make_voxel(1'b1, 16'h0200, 16'h0000, 16'h0000, 16'h0100, 1'b0));
      send_voxel(make_voxel(1'b1, 16'h0300, 16'h0000, 16'h0000, 16'h0100, 1'b0));
      write_row_len(XSizeW'(2));
      send_voxel(make_voxel(1'b1, 16'h2000, 16'h0000, 16'h0000, 16'hFFFF, 1'b0));
      send_voxel(make_voxel(1'b1, 16'h0400, 16'h0000, 16'h0000, 16'h0100, 1'b0));
      send_voxel(make_voxel(1'b1, 16'h0000, 16'h0600, 16'h0000, 16'h0100, 1'b1));

      // The largest register value is clamped to the column limit, so a short
      // volume only touches the inflow sum.
      write_row_len('1);
      send_voxel(make_voxel(1'b1, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 1'b0));
      send_voxel(make_voxel(1'b1, 16'h8000, 16'h0000, 16'h0000, 16'h0100, 1'b0));
      send_voxel(make_voxel(1'b1, 16'h0100, 16'h0000, 16'h0000, 16'hFFFF, 1'b1));

      // Random part: whole volumes of random content make up most of it, with
      // some volumes cut at an odd length and, at the end of some phases, a
      // partial row left open so the next row length lands mid-row.
      gen_col = 0;
      for (int ph = 0; ph < NumPhases; ph++) begin
         if (ph < NumPhases / 3) begin
            send_gap_pct = 7;
            recv_gap_pct = 68;
         end else if (ph < 2 * NumPhases / 3) begin
            send_gap_pct = 68;
            recv_gap_pct = 7;
         end else begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
         end
         write_row_len(XSizeW'(phase_row_len[ph]));
         span = (phase_row_len[ph] == 0) ? 1 :
                ((phase_row_len[ph] > MaxColumns) ? MaxColumns : phase_row_len[ph]);
         sent = 0;
         vol  = 0;
         while (sent < ((span >= LongRow) ? 1 : ItemsPerPhase)) begin
            if ((ph == 0 && vol == 2) || $urandom_range(0, 49) == 0)
               wait_for_totals();
            if (span >= LongRow)
               len = span + $urandom_range(0, 3);
            else if ($urandom_range(0, 99) < 15)
               len = $urandom_range(1, 2 * span + 3);
            else
               len = span * $urandom_range(1, (span > 24) ? 1 : 48 / span);
            for (int i = 0; i < len; i++) begin
               // On a long row only the first and last columns and a sprinkle of
               // others are valid; invalid voxels skip the root iterations and pass through faster.
               if (span >= LongRow)
                  keep = (gen_col == 0) || (gen_col == span - 1) ||
                         ($urandom_range(0, 99) < 4);
               else
                  keep = ($urandom_range(0, 99) < 85);
               send_voxel(random_voxel(keep, i == len - 1));
               gen_col = (i == len - 1 || gen_col >= span - 1) ? 0 : gen_col + 1;
            end
            sent += len;
            vol++;
         end
         if (span < LongRow && $urandom_range(0, 1) == 1) begin
            len = $urandom_range(1, span);
            for (int i = 0; i < len; i++) begin
               send_voxel(random_voxel($urandom_range(0, 99) < 85, 1'b0));
               gen_col = (gen_col >= span - 1) ? 0 : gen_col + 1;
            end
         end
      end

      wait_for_totals();
      repeat (SettleCycles) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/vfs_pkg.sv
hdl/vfs_req_if.sv
hdl/vfs_rsp_if.sv
hdl/vfs_ctrl.sv
hdl/vfs_datapath.sv
hdl/volume_flow_statistics.sv
sim/volume_flow_statistics_tb.sv
